### rtl/cdc_pkg.sv
// shared types, op codes and defaults of the character cell depth compositor
`timescale 1ns / 1ps

package cdc_pkg;

   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 64;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_DRAW  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [6:0] HEIGHT_RESET = 7'd25;

   localparam logic [7:0]  BLANK_GLYPH = 8'h20;
   localparam logic [15:0] BLANK_COLOR = 16'h0000;
   localparam logic [15:0] BLANK_RANK  = 16'hFFFF;

   typedef struct packed {
      logic [15:0] rank;
      logic [15:0] color;
      logic [7:0]  glyph;
   } cell_type;

   localparam cell_type BLANK_CELL = '{rank: BLANK_RANK, color: BLANK_COLOR,
                                       glyph: BLANK_GLYPH};

endpackage

### rtl/cdc_cell_mem.sv
// single-port-write, single-port-read cell store with registered read data
`timescale 1ns / 1ps

module cdc_cell_mem #(
   parameter int DEPTH = cdc_pkg::MAX_COLS_DEF * cdc_pkg::MAX_ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  cdc_pkg::cell_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output cdc_pkg::cell_type rd_data
);
   import cdc_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cdc_locate.sv
// clips a cell position against the screen size and forms its store address
`timescale 1ns / 1ps

module cdc_locate #(
   parameter int MAX_COLS = cdc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = cdc_pkg::MAX_ROWS_DEF,
   parameter int AW       = $clog2(MAX_COLS * MAX_ROWS)
) (
   input  logic [7:0]        screen_width,
   input  logic [6:0]        screen_height,
   input  logic signed [11:0] col_base,
   input  logic [11:0]       col_offs,
   input  logic signed [11:0] row,
   output logic              hit,
   output logic [AW-1:0]     addr
);
   import cdc_pkg::*;

   logic signed [13:0] col_sum;
   logic [31:0]        w_lim;
   logic [31:0]        h_lim;
   logic [31:0]        idx;
   logic               col_ok;
   logic               row_ok;

   always_comb begin
      col_sum = 14'(col_base) + $signed({2'b00, col_offs});
      w_lim   = (32'(screen_width) < 32'(MAX_COLS)) ? 32'(screen_width) : 32'(MAX_COLS);
      h_lim   = (32'(screen_height) < 32'(MAX_ROWS)) ? 32'(screen_height) : 32'(MAX_ROWS);
      col_ok  = !col_sum[13] && (32'(col_sum[12:0]) < w_lim);
      row_ok  = !row[11] && (32'(row[10:0]) < h_lim);
      idx     = 32'(row[10:0]) * 32'(MAX_COLS) + 32'(col_sum[12:0]);
      hit     = col_ok && row_ok;
      addr    = idx[AW-1:0];
   end

endmodule

### rtl/char_cell_depth_compositor_unit.sv
// top level: character cell frame store with per-cell rank test
//
// input stream req_*: one beat per op (clear, draw, read), op code in req_tuser.
// result stream rsp_*: exactly one beat per accepted op, in order.
// config port csr_*: index 0 screen width, index 1 screen height, written when
// csr_we is high; write only while the block is idle.
// a draw or read reads the cell from the store at the accept edge; once the
// output register is free, the rank compare, write-back and result register
// load happen; a new op is accepted once that result sits in rsp_tdata, so an
// op is not taken before the last one is through, as the read-modify-write on
// the single cell store requires.
// a clear writes blanks to all MAX_COLS * MAX_ROWS cells, one per cycle, then
// delivers its result.
// after reset the same sweep runs with req_tready low; config writes are taken
// during it.
// when rsp_tready is low the result holds in the output register; one further
// op may be accepted and waits for the register to free up.
`timescale 1ns / 1ps

module char_cell_depth_compositor_unit #(
   parameter int MAX_COLS = cdc_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = cdc_pkg::MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // start_col, row, char_offset, glyph, color, depth_rank, zero pad
   input  logic [79:0] req_tdata,
   // op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_glyph, out_color, out_rank, written, zero pad
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);
   import cdc_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          sweep_reply_ff, sweep_reply_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cell_type      rsp_cell_ff, rsp_cell_in;
   logic          rsp_written_ff, rsp_written_in;
   logic [7:0]    width_ff;
   logic [6:0]    height_ff;

   logic [1:0]    op_ff;
   logic          hit_ff;
   logic [AW-1:0] addr_ff;
   cell_type      new_cell_ff;

   logic          accept;
   logic          out_free;
   logic          loc_hit;
   logic [AW-1:0] loc_addr;
   logic [11:0]   loc_offs;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   cell_type      mem_wdata;
   cell_type      mem_rdata;
   logic          rank_win;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign loc_offs   = (req_tuser == OP_DRAW) ? req_tdata[35:24] : 12'd0;

   cdc_locate #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .AW       (AW)
   ) u_locate (
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .col_base      ($signed(req_tdata[11:0])),
      .col_offs      (loc_offs),
      .row           ($signed(req_tdata[23:12])),
      .hit           (loc_hit),
      .addr          (loc_addr)
   );

   cdc_cell_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (accept),
      .rd_addr (loc_addr),
      .rd_data (mem_rdata)
   );

   assign rank_win = $signed(mem_rdata.rank) <= $signed(new_cell_ff.rank);

   always_comb begin
      state_in       = state_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      sweep_reply_in = sweep_reply_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_cell_in    = rsp_cell_ff;
      rsp_written_in = rsp_written_ff;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = new_cell_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_CLEAR) begin
                  state_in       = ST_SWEEP;
                  sweep_cnt_in   = '0;
                  sweep_reply_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            mem_we       = 1'b1;
            mem_waddr    = sweep_cnt_ff;
            mem_wdata    = BLANK_CELL;
            sweep_cnt_in = sweep_cnt_ff + AW'(1);
            if (sweep_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = sweep_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = BLANK_CELL;
               rsp_written_in = 1'b0;
               sweep_reply_in = 1'b0;
               state_in       = ST_IDLE;
               if (op_ff == OP_DRAW && hit_ff) begin
                  if (rank_win) begin
                     mem_we         = 1'b1;
                     rsp_cell_in    = new_cell_ff;
                     rsp_written_in = 1'b1;
                  end else begin
                     rsp_cell_in = mem_rdata;
                  end
               end else if (op_ff == OP_READ && hit_ff) begin
                  rsp_cell_in = mem_rdata;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_cnt_ff   <= '0;
         sweep_reply_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         sweep_reply_ff <= sweep_reply_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata[6:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff    <= rsp_cell_in;
      rsp_written_ff <= rsp_written_in;
      if (accept) begin
         op_ff             <= req_tuser;
         hit_ff            <= loc_hit;
         addr_ff           <= loc_addr;
         new_cell_ff.glyph <= req_tdata[43:36];
         new_cell_ff.color <= req_tdata[59:44];
         new_cell_ff.rank  <= req_tdata[75:60];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_written_ff, rsp_cell_ff.rank, rsp_cell_ff.color,
                        rsp_cell_ff.glyph};

   // finishing an op always leaves a beat in the output register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished op produced no result beat");

   // the store is only written by the sweep or by a winning draw
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SWEEP || (state_ff == ST_DONE && op_ff == OP_DRAW)))
      else $error("cell store written outside sweep or draw");

   // the sweep ends right after its last cell
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && sweep_cnt_ff == AW'(DEPTH - 1)) |=> state_ff != ST_SWEEP)
      else $error("sweep ran past the last cell");

   // a written flag only follows a draw on a visible cell
   a_written_draw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && rsp_written_in) |-> (op_ff == OP_DRAW && hit_ff))
      else $error("written flag set without a visible draw");

endmodule

### dv/cell_result_checker.sv
// checker: mirrors the frame store, predicts every result beat and compares it field by field
`timescale 1ns / 1ps

module cell_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // start_col, row, char_offset, glyph, color, depth_rank, zero pad
   input  logic [79:0] req_tdata,
   // op
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_glyph, out_color, out_rank, written, zero pad
   input  logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          stored_count
);
   import cdc_pkg::*;

   localparam int CELL_COUNT = MAX_COLS_DEF * MAX_ROWS_DEF;

   typedef struct packed {
      logic        written;
      logic [15:0] rank;
      logic [15:0] color;
      logic [7:0]  glyph;
   } cell_result_type;

   cell_type        frame[CELL_COUNT];
   logic [7:0]      width_reg = WIDTH_RESET;
   logic [6:0]      height_reg = HEIGHT_RESET;
   cell_result_type results_due[$];
   int              errors = 0;
   int              stores = 0;

   function automatic void blank_frame();
      for (int i = 0; i < CELL_COUNT; i++) frame[i] = BLANK_CELL;
   endfunction

   function automatic cell_result_type compose_cell(input logic [1:0] op,
                                                    input logic [79:0] d);
      int              col;
      int              row;
      int              w;
      int              h;
      int              idx;
      logic [15:0]     rank_new;
      cell_result_type res;
      col = int'($signed(d[11:0]));
      row = int'($signed(d[23:12]));
      rank_new = d[75:60];
      w = (width_reg < MAX_COLS_DEF) ? int'(width_reg) : MAX_COLS_DEF;
      h = (height_reg < MAX_ROWS_DEF) ? int'(height_reg) : MAX_ROWS_DEF;
      res = '{written: 1'b0, rank: BLANK_RANK, color: BLANK_COLOR, glyph: BLANK_GLYPH};
      case (op)
         OP_CLEAR: blank_frame();
         OP_DRAW, OP_READ: begin
            if (op == OP_DRAW) col = col + int'(d[35:24]);
            // cells off the configured screen are clipped
            if (col >= 0 && col < w && row >= 0 && row < h) begin
               idx = row * MAX_COLS_DEF + col;
               if (op == OP_DRAW && $signed(frame[idx].rank) <= $signed(rank_new)) begin
                  frame[idx] = '{rank: rank_new, color: d[59:44], glyph: d[43:36]};
                  res.written = 1'b1;
               end
               res.rank = frame[idx].rank;
               res.color = frame[idx].color;
               res.glyph = frame[idx].glyph;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      cell_result_type got;
      cell_result_type want;
      if (reset) begin
         blank_frame();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         results_due.delete();
         errors = 0;
         stores = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata[6:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[40:0];
            if (results_due.size() == 0) begin
               $error("result beat with no op waiting: %h", rsp_tdata);
               errors++;
            end else begin
               want = results_due.pop_front();
               if (got.glyph !== want.glyph) begin
                  $error("out_glyph mismatch: expected %h, got %h", want.glyph, got.glyph);
                  errors++;
               end
               if (got.color !== want.color) begin
                  $error("out_color mismatch: expected %h, got %h", want.color, got.color);
                  errors++;
               end
               if (got.rank !== want.rank) begin
                  $error("out_rank mismatch: expected %0d, got %0d",
                         $signed(want.rank), $signed(got.rank));
                  errors++;
               end
               if (got.written !== want.written) begin
                  $error("written mismatch: expected %b, got %b", want.written, got.written);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = compose_cell(req_tuser, req_tdata);
            if (want.written) stores++;
            results_due.push_back(want);
         end
      end
      fail_count <= errors;
      pending <= results_due.size();
      stored_count <= stores;
   end

endmodule

### dv/testbench.sv
// top: drives op beats and screen size writes into the compositor and reports the verdict
`timescale 1ns / 1ps

module testbench;
   import cdc_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int QUIET_LIMIT = 40000;
   localparam int PHASE_ITEMS = 85;
   localparam logic [7:0] PHASE_W [8] = '{8'd80, 8'd1, 8'd128, 8'd255, 8'd0, 8'd40, 8'd0, 8'd8};
   localparam logic [7:0] PHASE_H [8] = '{8'd25, 8'd1, 8'd64, 8'd255, 8'd25, 8'd0, 8'd0, 8'd4};
   localparam int PHASE_IDLE [4] = '{0, 87, 0, 8};
   localparam int PHASE_STALL [4] = '{0, 0, 87, 8};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_WIDTH;
   logic [7:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int stored_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet = 0;
   int n_draw = 0;
   int n_read = 0;
   int n_clear = 0;
   int n_none = 0;
   int n_sizes = 0;
   int scr_w = 80;
   int scr_h = 25;

   always #1 clock = ~clock;

   char_cell_depth_compositor_unit dut (.*);

   cell_result_checker results (.*);

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("char_cell_depth_compositor_unit test failed");
         $finish;
      end
   end

   function automatic logic [79:0] pack_op(input int scol, input int row, input int offs,
                                           input int glyph, input int color, input int rank);
      return {4'd0, 16'(rank), 16'(color), 8'(glyph), 12'(offs), 12'(row), 12'(scol)};
   endfunction

   // mostly near the origin or anywhere up to just past the screen edge, now and then anywhere
   function automatic int aim(input int span);
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 7);
      if (r < 9) return $urandom_range(0, span + 1);
      return int'($signed(12'($urandom)));
   endfunction

   task automatic send_op(input logic [1:0] op, input logic [79:0] data);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_CLEAR: n_clear++;
         OP_DRAW:  n_draw++;
         OP_READ:  n_read++;
         default:  n_none++;
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_phase(input logic [7:0] w, input logic [7:0] h, input int idle,
                            input int stall);
      drain();
      repeat (4) @(posedge clock);
      idle_pct <= idle;
      stall_pct <= stall;
      csr_we <= 1'b1;
      csr_addr <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      scr_w = (w < 128) ? int'(w) : 128;
      scr_h = (h[6:0] < 64) ? int'(h[6:0]) : 64;
      n_sizes++;
   endtask

   task automatic random_op();
      int         r;
      int         col;
      int         row;
      int         offs;
      int         scol;
      int         rank;
      logic [1:0] op;
      r = $urandom_range(0, 199);
      col = aim(scr_w);
      row = aim(scr_h);
      offs = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
      if (col - offs < -2048) offs = col + 2048;
      scol = col - offs;
      // narrow rank band so draws fight over the same cells
      rank = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) - 3 : $urandom_range(0, 65535);
      if (r == 0) op = OP_CLEAR;
      else if (r < 9) op = OP_NONE;
      else if (r < 110) op = OP_DRAW;
      else begin
         op = OP_READ;
         scol = col;
         offs = $urandom_range(0, 4095);
      end
      send_op(op, pack_op(scol, row, offs, $urandom_range(0, 255), $urandom_range(0, 65535),
                          rank));
   endtask

   initial begin
      logic [7:0] w;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_phase(8'd80, 8'd25, 0, 0);

      send_op(OP_READ, pack_op(0, 0, 0, 0, 0, 0));
      send_op(OP_DRAW, pack_op(0, 0, 0, 8'h41, 16'h1234, -1));
      send_op(OP_DRAW, pack_op(0, 0, 0, 8'h42, 16'h5678, -2));
      send_op(OP_DRAW, pack_op(-2048, 24, 2127, 255, 65535, 32767));
      send_op(OP_DRAW, pack_op(79, 24, 0, 0, 0, -32768));
      send_op(OP_DRAW, pack_op(80, 0, 0, 1, 1, 0));
      send_op(OP_DRAW, pack_op(76, 3, 4, 1, 1, 0));
      send_op(OP_DRAW, pack_op(0, 25, 0, 1, 1, 0));
      send_op(OP_DRAW, pack_op(0, -1, 0, 1, 1, 0));
      send_op(OP_DRAW, pack_op(-1, 0, 0, 1, 1, 0));
      send_op(OP_DRAW, pack_op(-2048, 0, 4095, 1, 1, 0));
      send_op(OP_DRAW, pack_op(2047, 2047, 4095, 255, 65535, 32767));
      send_op(OP_READ, pack_op(79, 24, 4095, 0, 0, 0));
      send_op(OP_READ, pack_op(0, 0, 0, 0, 0, 0));
      send_op(OP_READ, pack_op(-2048, -2048, 0, 0, 0, 0));
      send_op(OP_READ, pack_op(2047, 2047, 0, 0, 0, 0));
      send_op(OP_NONE, {4'd0, {76{1'b1}}});
      send_op(OP_CLEAR, pack_op(5, 5, 5, 5, 5, 5));
      send_op(OP_READ, pack_op(79, 24, 0, 0, 0, 0));
      send_op(OP_READ, pack_op(0, 0, 0, 0, 0, 0));

      for (int p = 0; p < 8; p++) begin
         w = (p == 6) ? 8'($urandom_range(1, 128)) : PHASE_W[p];
         set_phase(w, (p == 6) ? 8'($urandom_range(1, 64)) : PHASE_H[p],
                   PHASE_IDLE[p % 4], PHASE_STALL[p % 4]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 63) == 0) drain();
            random_op();
         end
      end

      drain();
      repeat (16) @(posedge clock);
      $display("covered %0d draws (%0d stored), %0d reads, %0d clears, %0d unused op beats",
               n_draw, stored_count, n_read, n_clear, n_none);
      $display("over %0d screen size settings, from zero-sized up to capped oversize",
               n_sizes);
      if (fail_count == 0 && pending == 0) begin
         $display("char_cell_depth_compositor_unit test passed");
      end else begin
         $display("char_cell_depth_compositor_unit test failed");
      end
      $finish;
   end

endmodule
